### rtl/cbv_pkg.sv
// Shared constants, types and helper functions for the calibration blob validator.
package cbv_pkg;

   localparam int CHANNELS   = 4;
   localparam int BOUNDARIES = 6;
   localparam int STRING_MAX = 32;
   localparam int BLOB_LIMIT = 324;

   localparam int CH_W      = $clog2(CHANNELS);
   localparam int CC_W      = $clog2(CHANNELS + 1);
   localparam int AN_W      = $clog2(BOUNDARIES);
   localparam int FC_W      = 8;
   localparam int BC_W      = $clog2(BLOB_LIMIT + 2);
   localparam int ANCHOR_W  = 16;
   localparam int ADDR_W    = CH_W + 1 + AN_W;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CSR_IDX_W  = 2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [CSR_IDX_W-1:0] CSR_VERSION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIER    = 2'd2;

   typedef enum logic [3:0] {
      R_NONE      = 4'd0,
      R_LENGTH    = 4'd1,
      R_MAGIC     = 4'd2,
      R_VERSION   = 4'd3,
      R_CRC       = 4'd4,
      R_CHANNELS  = 4'd5,
      R_PRESENT   = 4'd6,
      R_TRUNC     = 4'd7,
      R_CLASS     = 4'd8,
      R_TIER      = 4'd9,
      R_ORDER     = 4'd10,
      R_STRING    = 4'd11,
      R_TRAILING  = 4'd12
   } reason_type;

   typedef enum logic [10:0] {
      PH_MAGIC   = 11'b000_0000_0001,
      PH_VERSION = 11'b000_0000_0010,
      PH_COUNT   = 11'b000_0000_0100,
      PH_PRESENT = 11'b000_0000_1000,
      PH_CLASS   = 11'b000_0001_0000,
      PH_TIER    = 11'b000_0010_0000,
      PH_ANCHOR  = 11'b000_0100_0000,
      PH_STRLEN  = 11'b000_1000_0000,
      PH_STRBODY = 11'b001_0000_0000,
      PH_DONE    = 11'b010_0000_0000,
      PH_HALT    = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] version;
      logic [7:0] cls;
      logic [7:0] tier;
   } cfg_type;

   typedef struct packed {
      logic       present;
      logic [7:0] cls;
      logic [7:0] tier;
   } slot_type;

   typedef struct packed {
      logic                en;
      logic [CH_W-1:0]     ch;
      logic [AN_W-1:0]     idx;
      logic [ANCHOR_W-1:0] data;
   } anchor_wr_type;

   typedef struct packed {
      logic       done;
      reason_type reason;
   } blob_end_type;

   typedef struct packed {
      logic                kind;
      logic                accepted;
      logic [3:0]          reason;
      logic                present;
      logic [7:0]          cls;
      logic [7:0]          tier;
      logic [ANCHOR_W-1:0] anchor;
   } result_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] pos);
      logic [7:0] m;
      unique case (pos)
         2'd0:    m = 8'h53;  // S
         2'd1:    m = 8'h50;  // P
         2'd2:    m = 8'h43;  // C
         default: m = 8'h4C;  // L
      endcase
      return m;
   endfunction

   // CRC-16/CCITT-FALSE, one byte, msb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

### rtl/cbv_anchor_ram.sv
// Simple dual-port anchor RAM, one write and one registered read port.
module cbv_anchor_ram #(
   parameter int AW = 6,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [2**AW];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cbv_parser.sv
// Blob byte delay, CRC, record parser, staged slot table and final status.
module cbv_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_go,
   input  logic [7:0]              blob_byte,
   input  logic                    last_byte,
   input  cbv_pkg::cfg_type        cfg,
   output cbv_pkg::anchor_wr_type  wr,
   output cbv_pkg::blob_end_type   fin,
   output cbv_pkg::slot_type       staged_next [cbv_pkg::CHANNELS]
);

   logic [15:0]                 held_ff, held_in;
   logic [cbv_pkg::BC_W-1:0]    count_ff, count_in;
   logic [15:0]                 crc_ff, crc_in;
   cbv_pkg::phase_type          phase_ff, phase_in;
   logic [cbv_pkg::FC_W-1:0]    fc_ff, fc_in;
   logic [cbv_pkg::CC_W-1:0]    cc_ff, cc_in;
   logic [cbv_pkg::CC_W-1:0]    decl_ff, decl_in;
   logic [2:0]                  hflags_ff, hflags_in;   // channels, version, magic
   cbv_pkg::reason_type         perr_ff, perr_in;
   logic [15:0]                 prev_ff, prev_in;
   logic [2:0]                  rflags_ff, rflags_in;   // order, tier, class
   logic                        sidx_ff, sidx_in;
   logic [7:0]                  lo_ff, lo_in;
   cbv_pkg::slot_type           staged_ff [cbv_pkg::CHANNELS];
   cbv_pkg::slot_type           staged_in [cbv_pkg::CHANNELS];

   logic [7:0]                  leaving;
   logic [cbv_pkg::CH_W-1:0]    ch;
   logic [cbv_pkg::CC_W-1:0]    cc_inc;
   logic [cbv_pkg::AN_W-1:0]    aidx;
   logic [15:0]                 v;
   logic [15:0]                 want;

   assign leaving = held_ff[15:8];
   assign ch      = cc_ff[cbv_pkg::CH_W-1:0];
   assign cc_inc  = cc_ff + 1'b1;
   assign aidx    = fc_ff[cbv_pkg::AN_W:1];
   assign v       = {leaving, lo_ff};

   always_comb begin
      held_in   = held_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      phase_in  = phase_ff;
      fc_in     = fc_ff;
      cc_in     = cc_ff;
      decl_in   = decl_ff;
      hflags_in = hflags_ff;
      perr_in   = perr_ff;
      prev_in   = prev_ff;
      rflags_in = rflags_ff;
      sidx_in   = sidx_ff;
      lo_in     = lo_ff;
      staged_in = staged_ff;
      wr        = '0;
      fin       = '{done: 1'b0, reason: cbv_pkg::R_NONE};
      want      = '0;

      if (byte_go) begin
         if (count_ff >= cbv_pkg::BC_W'(2)) begin
            crc_in = cbv_pkg::crc_byte(crc_ff, leaving);
            unique case (phase_ff)
               cbv_pkg::PH_MAGIC: begin
                  if (leaving != cbv_pkg::magic_byte(fc_ff[1:0])) hflags_in[0] = 1'b1;
                  if (fc_ff >= cbv_pkg::FC_W'(3)) begin
                     fc_in    = '0;
                     phase_in = cbv_pkg::PH_VERSION;
                  end else begin
                     fc_in = fc_ff + 1'b1;
                  end
               end
               cbv_pkg::PH_VERSION: begin
                  if (leaving != cfg.version) hflags_in[1] = 1'b1;
                  phase_in = cbv_pkg::PH_COUNT;
               end
               cbv_pkg::PH_COUNT: begin
                  decl_in = leaving[cbv_pkg::CC_W-1:0];
                  cc_in   = '0;
                  if (leaving > 8'(cbv_pkg::CHANNELS)) begin
                     hflags_in[2] = 1'b1;
                     phase_in     = cbv_pkg::PH_HALT;
                  end else begin
                     phase_in = (leaving == 8'd0) ? cbv_pkg::PH_DONE : cbv_pkg::PH_PRESENT;
                  end
               end
               cbv_pkg::PH_PRESENT: begin
                  if (leaving > 8'd1) begin
                     if (perr_ff == cbv_pkg::R_NONE) perr_in = cbv_pkg::R_PRESENT;
                     phase_in = cbv_pkg::PH_HALT;
                  end else if (leaving == 8'd0) begin
                     cc_in    = cc_inc;
                     phase_in = (cc_inc >= decl_ff) ? cbv_pkg::PH_DONE : cbv_pkg::PH_PRESENT;
                  end else begin
                     phase_in = cbv_pkg::PH_CLASS;
                  end
               end
               cbv_pkg::PH_CLASS: begin
                  rflags_in         = {2'b00, leaving != cfg.cls};
                  staged_in[ch].cls = leaving;
                  phase_in          = cbv_pkg::PH_TIER;
               end
               cbv_pkg::PH_TIER: begin
                  if (leaving > cfg.tier) rflags_in[1] = 1'b1;
                  staged_in[ch].tier = leaving;
                  fc_in              = '0;
                  phase_in           = cbv_pkg::PH_ANCHOR;
               end
               cbv_pkg::PH_ANCHOR: begin
                  if (!fc_ff[0]) begin
                     lo_in = leaving;
                  end else begin
                     wr.en   = 1'b1;
                     wr.ch   = ch;
                     wr.idx  = aidx;
                     wr.data = v;
                     if (aidx != '0 && v >= prev_ff) rflags_in[2] = 1'b1;
                     prev_in = v;
                  end
                  fc_in = fc_ff + 1'b1;
                  if (fc_in >= cbv_pkg::FC_W'(2 * cbv_pkg::BOUNDARIES)) begin
                     priority if (rflags_in[0]) begin
                        if (perr_ff == cbv_pkg::R_NONE) perr_in = cbv_pkg::R_CLASS;
                        phase_in = cbv_pkg::PH_HALT;
                     end else if (rflags_in[1]) begin
                        if (perr_ff == cbv_pkg::R_NONE) perr_in = cbv_pkg::R_TIER;
                        phase_in = cbv_pkg::PH_HALT;
                     end else if (rflags_in[2]) begin
                        if (perr_ff == cbv_pkg::R_NONE) perr_in = cbv_pkg::R_ORDER;
                        phase_in = cbv_pkg::PH_HALT;
                     end else begin
                        fc_in    = '0;
                        sidx_in  = 1'b0;
                        phase_in = cbv_pkg::PH_STRLEN;
                     end
                  end
               end
               cbv_pkg::PH_STRLEN: begin
                  if (9'(leaving) >= 9'(cbv_pkg::STRING_MAX)) begin
                     if (perr_ff == cbv_pkg::R_NONE) perr_in = cbv_pkg::R_STRING;
                     phase_in = cbv_pkg::PH_HALT;
                  end else if (leaving == 8'd0) begin
                     if (!sidx_ff) begin
                        sidx_in  = 1'b1;
                        phase_in = cbv_pkg::PH_STRLEN;
                     end else begin
                        staged_in[ch].present = 1'b1;
                        cc_in    = cc_inc;
                        phase_in = (cc_inc >= decl_ff) ? cbv_pkg::PH_DONE : cbv_pkg::PH_PRESENT;
                     end
                  end else begin
                     fc_in    = leaving;
                     phase_in = cbv_pkg::PH_STRBODY;
                  end
               end
               cbv_pkg::PH_STRBODY: begin
                  fc_in = fc_ff - 1'b1;
                  if (fc_in == '0) begin
                     if (!sidx_ff) begin
                        sidx_in  = 1'b1;
                        phase_in = cbv_pkg::PH_STRLEN;
                     end else begin
                        staged_in[ch].present = 1'b1;
                        cc_in    = cc_inc;
                        phase_in = (cc_inc >= decl_ff) ? cbv_pkg::PH_DONE : cbv_pkg::PH_PRESENT;
                     end
                  end
               end
               cbv_pkg::PH_DONE: begin
                  if (perr_ff == cbv_pkg::R_NONE) perr_in = cbv_pkg::R_TRAILING;
                  phase_in = cbv_pkg::PH_HALT;
               end
               cbv_pkg::PH_HALT: begin
               end
               default: begin
               end
            endcase
         end
         held_in = {held_ff[7:0], blob_byte};
         if (count_ff <= cbv_pkg::BC_W'(cbv_pkg::BLOB_LIMIT)) count_in = count_ff + 1'b1;
      end

      staged_next = staged_in;

      if (byte_go && last_byte) begin
         // trailing two bytes carry the CRC, low byte first
         want     = {held_in[7:0], held_in[15:8]};
         fin.done = 1'b1;
         priority if (count_in < cbv_pkg::BC_W'(8) ||
                      count_in > cbv_pkg::BC_W'(cbv_pkg::BLOB_LIMIT)) begin
            fin.reason = cbv_pkg::R_LENGTH;
         end else if (hflags_in[0]) begin
            fin.reason = cbv_pkg::R_MAGIC;
         end else if (hflags_in[1]) begin
            fin.reason = cbv_pkg::R_VERSION;
         end else if (crc_in != want) begin
            fin.reason = cbv_pkg::R_CRC;
         end else if (hflags_in[2]) begin
            fin.reason = cbv_pkg::R_CHANNELS;
         end else if (perr_in != cbv_pkg::R_NONE) begin
            fin.reason = perr_in;
         end else if (phase_in == cbv_pkg::PH_DONE) begin
            fin.reason = cbv_pkg::R_NONE;
         end else if (phase_in == cbv_pkg::PH_STRBODY) begin
            fin.reason = cbv_pkg::R_STRING;
         end else begin
            fin.reason = cbv_pkg::R_TRUNC;
         end

         // next byte opens a new blob
         held_in   = '0;
         count_in  = '0;
         crc_in    = cbv_pkg::CRC_INIT;
         phase_in  = cbv_pkg::PH_MAGIC;
         fc_in     = '0;
         cc_in     = '0;
         decl_in   = '0;
         hflags_in = '0;
         perr_in   = cbv_pkg::R_NONE;
         prev_in   = '0;
         rflags_in = '0;
         sidx_in   = 1'b0;
         for (int c = 0; c < cbv_pkg::CHANNELS; c++) begin
            staged_in[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         count_ff  <= '0;
         crc_ff    <= cbv_pkg::CRC_INIT;
         phase_ff  <= cbv_pkg::PH_MAGIC;
         fc_ff     <= '0;
         cc_ff     <= '0;
         decl_ff   <= '0;
         hflags_ff <= '0;
         perr_ff   <= cbv_pkg::R_NONE;
         prev_ff   <= '0;
         rflags_ff <= '0;
         sidx_ff   <= 1'b0;
         for (int c = 0; c < cbv_pkg::CHANNELS; c++) begin
            staged_ff[c] <= '0;
         end
      end else begin
         held_ff   <= held_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         phase_ff  <= phase_in;
         fc_ff     <= fc_in;
         cc_ff     <= cc_in;
         decl_ff   <= decl_in;
         hflags_ff <= hflags_in;
         perr_ff   <= perr_in;
         prev_ff   <= prev_in;
         rflags_ff <= rflags_in;
         sidx_ff   <= sidx_in;
         staged_ff <= staged_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
   end

endmodule

### rtl/cbv_result_fifo.sv
// Four-entry result queue between the pipeline and the response port.
module cbv_result_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  cbv_pkg::result_type          din,
   input  logic                         pop,
   output cbv_pkg::result_type          dout,
   output logic                         valid,
   output logic [cbv_pkg::FIFO_AW:0]    count
);

   cbv_pkg::result_type            mem_ff [cbv_pkg::FIFO_DEPTH];
   logic [cbv_pkg::FIFO_AW-1:0]    wp_ff, wp_in;
   logic [cbv_pkg::FIFO_AW-1:0]    rp_ff, rp_in;
   logic [cbv_pkg::FIFO_AW:0]      cnt_ff, cnt_in;
   logic                           do_pop;

   assign valid  = (cnt_ff != '0);
   assign do_pop = pop && valid;
   assign dout   = mem_ff[rp_ff];
   assign count  = cnt_ff;

   always_comb begin
      wp_in  = push   ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= din;
      end
   end

endmodule

### rtl/calibration_blob_validator_core.sv
// Top level of the calibration blob validator: config, live store, read pipe, response queue.
// Takes one request per cycle, back to back, while req_ready is high. A blob byte request
// (opcode 0) feeds the two-byte CRC delay, the CRC and the record parser in the cycle it is
// accepted; only the final byte gives a response (accepted flag and reject reason), through
// the pipe stage and the response queue. A read request (opcode 1) reads one anchor from the
// anchor RAM through its registered read port, which the pipe stage waits on. Responses leave
// in request order through a four-entry queue; req_ready drops only when the queue entries
// plus the stage in front of it reach four. Anchors live in one RAM that holds two banks per
// channel: a blob writes the bank that is not live, and an accepted blob commits by flipping
// the bank bit of each slot it filled, so there is no copy pass and no clearing pass after
// reset. Slots a blob does not fill read as empty with zero class, tier and anchors. Config
// registers (0 version, 1 sensor class, 2 highest tier) are written through csr_ at any time
// with no wait; write them only between blobs.
module calibration_blob_validator_core (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_opcode,
   input  logic [7:0]                     req_blob_byte,
   input  logic                           req_last_byte,
   input  logic [1:0]                     req_read_channel,
   input  logic [2:0]                     req_read_anchor,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_result_kind,
   output logic                           rsp_accepted,
   output logic [3:0]                     rsp_reject_reason,
   output logic                           rsp_slot_present,
   output logic [7:0]                     rsp_slot_class,
   output logic [7:0]                     rsp_slot_tier,
   output logic [15:0]                    rsp_anchor_value,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cbv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                     csr_wdata
);

   cbv_pkg::cfg_type                cfg_ff;
   cbv_pkg::slot_type               live_ff [cbv_pkg::CHANNELS];
   logic [cbv_pkg::CHANNELS-1:0]    bank_ff;

   // stage between request accept and the response queue (waits on RAM data)
   logic                            p_valid_ff, p_valid_in;
   cbv_pkg::result_type             p_res_ff, p_res_in;
   logic                            p_anchor_ok_ff, p_anchor_ok_in;

   logic                            req_go, byte_go, rd_go, commit;
   cbv_pkg::anchor_wr_type          wr;
   cbv_pkg::blob_end_type           fin;
   cbv_pkg::slot_type               staged_next [cbv_pkg::CHANNELS];
   logic [cbv_pkg::ADDR_W-1:0]      wr_addr, rd_addr;
   logic [cbv_pkg::ANCHOR_W-1:0]    ram_q;
   cbv_pkg::result_type             push_data, fifo_dout;
   logic                            fifo_valid;
   logic [cbv_pkg::FIFO_AW:0]       fifo_count;
   logic [cbv_pkg::FIFO_AW+1:0]     occupancy;
   cbv_pkg::slot_type               rd_slot;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.version <= 8'd1;
         cfg_ff.cls     <= 8'd0;
         cfg_ff.tier    <= 8'd2;
      end else if (csr_valid) begin
         if (csr_index == cbv_pkg::CSR_VERSION) cfg_ff.version <= csr_wdata;
         if (csr_index == cbv_pkg::CSR_CLASS)   cfg_ff.cls     <= csr_wdata;
         if (csr_index == cbv_pkg::CSR_TIER)    cfg_ff.tier    <= csr_wdata;
      end
   end

   // the pipe stage always drains into the queue next cycle, so count it as taken
   assign occupancy = {1'b0, fifo_count} + (cbv_pkg::FIFO_AW+2)'(p_valid_ff);
   assign req_ready = occupancy < (cbv_pkg::FIFO_AW+2)'(cbv_pkg::FIFO_DEPTH);
   assign req_go    = req_valid && req_ready;
   assign byte_go   = req_go && !req_opcode;
   assign rd_go     = req_go && req_opcode;
   assign commit    = fin.done && (fin.reason == cbv_pkg::R_NONE);

   cbv_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_go     (byte_go),
      .blob_byte   (req_blob_byte),
      .last_byte   (req_last_byte),
      .cfg         (cfg_ff),
      .wr          (wr),
      .fin         (fin),
      .staged_next (staged_next)
   );

   // staged records go to the bank that is not live
   assign wr_addr = {wr.ch, ~bank_ff[wr.ch], wr.idx};
   assign rd_addr = {req_read_channel, bank_ff[req_read_channel], req_read_anchor};

   cbv_anchor_ram #(
      .AW (cbv_pkg::ADDR_W),
      .DW (cbv_pkg::ANCHOR_W)
   ) u_anchor_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr_addr),
      .wr_data (wr.data),
      .rd_en   (rd_go),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // commit: flip banks of filled slots, drop the rest
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= '0;
         for (int c = 0; c < cbv_pkg::CHANNELS; c++) begin
            live_ff[c].present <= 1'b0;
         end
      end else if (commit) begin
         for (int c = 0; c < cbv_pkg::CHANNELS; c++) begin
            if (staged_next[c].present) begin
               live_ff[c] <= staged_next[c];
               bank_ff[c] <= ~bank_ff[c];
            end else begin
               live_ff[c].present <= 1'b0;
            end
         end
      end
   end

   assign rd_slot = live_ff[req_read_channel];

   always_comb begin
      p_valid_in     = rd_go || fin.done;
      p_res_in       = '0;
      p_anchor_ok_in = 1'b0;
      if (rd_go) begin
         p_res_in.kind    = 1'b1;
         p_res_in.present = rd_slot.present;
         p_res_in.cls     = rd_slot.present ? rd_slot.cls  : 8'd0;
         p_res_in.tier    = rd_slot.present ? rd_slot.tier : 8'd0;
         p_anchor_ok_in   = rd_slot.present &&
                            (4'(req_read_anchor) < 4'(cbv_pkg::BOUNDARIES));
      end else begin
         p_res_in.accepted = commit;
         p_res_in.reason   = fin.reason;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_res_ff       <= p_res_in;
      p_anchor_ok_ff <= p_anchor_ok_in;
   end

   always_comb begin
      push_data        = p_res_ff;
      push_data.anchor = p_anchor_ok_ff ? ram_q : '0;
   end

   cbv_result_fifo u_result_fifo (
      .clock (clock),
      .reset (reset),
      .push  (p_valid_ff),
      .din   (push_data),
      .pop   (rsp_ready),
      .dout  (fifo_dout),
      .valid (fifo_valid),
      .count (fifo_count)
   );

   assign rsp_valid         = fifo_valid;
   assign rsp_result_kind   = fifo_dout.kind;
   assign rsp_accepted      = fifo_dout.accepted;
   assign rsp_reject_reason = fifo_dout.reason;
   assign rsp_slot_present  = fifo_dout.present;
   assign rsp_slot_class    = fifo_dout.cls;
   assign rsp_slot_tier     = fifo_dout.tier;
   assign rsp_anchor_value  = fifo_dout.anchor;

   // queue never overflows: a full queue means nothing waits in the pipe stage
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_count == (cbv_pkg::FIFO_AW+1)'(cbv_pkg::FIFO_DEPTH) |-> !p_valid_ff)
      else $error("response queue overflow");

   a_read_pipes: assert property (@(posedge clock) disable iff (reset)
      rd_go |=> p_valid_ff && p_res_ff.kind)
      else $error("read request lost in pipe");

   a_mid_byte_silent: assert property (@(posedge clock) disable iff (reset)
      byte_go && !req_last_byte |=> !p_valid_ff)
      else $error("non-final blob byte produced a response");

   a_accept_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |->
         rsp_accepted == (rsp_reject_reason == 4'(cbv_pkg::R_NONE)))
      else $error("accepted flag disagrees with reject reason");

endmodule
